FILE: hw/rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg: shared types and constants of the positional list engine
// Item layouts, operation and status codes and the default list capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 64;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned LEN_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_READ       = 3'd2,
    OP_FIND       = 3'd3,
    OP_REMOVE_ALL = 3'd4,
    OP_LENGTH     = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic        [OP_W-1:0]  op;
    logic        [IDX_W-1:0] index;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [VAL_W-1:0]    read_value;
    logic        [POS_W-1:0]    found_position;
    logic        [LEN_W-1:0]    length;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/plm_mem.sv
// ----------------------------------------------------------------------------
// plm_mem: element store of the positional list engine
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_mem
  import plm_pkg::*;
#(
  parameter  int unsigned Depth = CAPACITY_DEFAULT,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem_q [Depth];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/plm_ctrl.sv
// ----------------------------------------------------------------------------
// plm_ctrl: sequencer of the positional list engine
// Checks each request, then where needed walks the element store one entry per cycle
// through a shared pointer step and comparator to shift, search or compact.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_ctrl
  import plm_pkg::*;
#(
  parameter  int unsigned Capacity = CAPACITY_DEFAULT,
  localparam int unsigned AW       = $clog2(Capacity)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire req_t             req_i,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output rsp_t                  rsp_o,
  output logic                  mem_we_o,
  output logic      [AW-1:0]    mem_waddr_o,
  output logic      [VAL_W-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic      [AW-1:0]    mem_raddr_o,
  input  wire logic [VAL_W-1:0] mem_rdata_i
);

  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned LW   = (CW > LEN_W) ? CW : LEN_W;
  localparam int unsigned FPW  = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PUT,
    S_DONE
  } state_e;

  state_e           state_q,  state_d;
  logic [OP_W-1:0]  op_q,     op_d;
  logic [AW-1:0]    idx_q,    idx_d;
  logic [VAL_W-1:0] val_q,    val_d;
  logic [CW-1:0]    cnt_q,    cnt_d;
  logic [AW-1:0]    ptr_q,    ptr_d;
  logic [AW-1:0]    stop_q,   stop_d;
  logic             iss_q,    iss_d;
  logic             rvld_q,   rvld_d;
  logic [AW-1:0]    raddr_q,  raddr_d;
  logic [CW-1:0]    keep_q,   keep_d;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] rd_q,     rd_d;
  logic [AW-1:0]    fpos_q,   fpos_d;

  logic [CMPW-1:0] idx_w;
  logic [CMPW-1:0] idx_p1;
  logic [CMPW-1:0] cnt_w;
  logic [CW-1:0]   cnt_m1;
  logic            list_full;
  logic            match;
  logic            last_iss;
  logic [LW-1:0]   len_w;
  logic [FPW-1:0]  fpos_w;

  assign idx_w     = CMPW'(req_i.index);
  assign idx_p1    = idx_w + CMPW'(1);
  assign cnt_w     = CMPW'(cnt_q);
  assign cnt_m1    = cnt_q - CW'(1);
  assign list_full = (cnt_q == CW'(Capacity));
  // The one comparator: each element read back against the request value.
  assign match     = (mem_rdata_i == val_q);
  assign last_iss  = (ptr_q == stop_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    stop_d      = stop_q;
    iss_d       = iss_q;
    rvld_d      = rvld_q;
    raddr_d     = raddr_q;
    keep_d      = keep_q;
    status_d    = status_q;
    rd_d        = rd_q;
    fpos_d      = fpos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.op;
          val_d    = req_i.value;
          idx_d    = idx_w[AW-1:0];
          status_d = ST_OK;
          rd_d     = '0;
          fpos_d   = '0;
          keep_d   = '0;
          iss_d    = 1'b0;
          rvld_d   = 1'b0;
          state_d  = S_DONE;
          unique case (req_i.op)
            OP_INSERT: begin
              if (idx_w > cnt_w) begin
                status_d = ST_BAD_POS;
              end else if (list_full) begin
                status_d = ST_FULL;
              end else if (idx_w == cnt_w) begin
                // Appending needs no shift.
                mem_we_o    = 1'b1;
                mem_waddr_o = idx_w[AW-1:0];
                mem_wdata_o = req_i.value;
                cnt_d       = cnt_q + CW'(1);
              end else begin
                ptr_d   = cnt_m1[AW-1:0];
                stop_d  = idx_w[AW-1:0];
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            OP_REMOVE: begin
              if (idx_w >= cnt_w) begin
                status_d = ST_BAD_POS;
              end else if (idx_p1 == cnt_w) begin
                cnt_d = cnt_m1;
              end else begin
                ptr_d   = idx_p1[AW-1:0];
                stop_d  = cnt_m1[AW-1:0];
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            OP_READ: begin
              if (idx_w >= cnt_w) begin
                status_d = ST_BAD_POS;
              end else begin
                ptr_d   = idx_w[AW-1:0];
                stop_d  = idx_w[AW-1:0];
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            OP_FIND, OP_REMOVE_ALL: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ptr_d   = '0;
                stop_d  = cnt_m1[AW-1:0];
                iss_d   = 1'b1;
                state_d = S_WALK;
              end
            end
            OP_LENGTH: begin
            end
            default: begin
              status_d = ST_BAD_POS;
            end
          endcase
        end
      end

      S_WALK: begin
        // Issue the next read; the store registers its read data.
        if (iss_q) begin
          mem_re_o = 1'b1;
          raddr_d  = ptr_q;
          rvld_d   = 1'b1;
          iss_d    = !last_iss;
          ptr_d    = (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
        end else begin
          rvld_d = 1'b0;
        end

        if (rvld_q) begin
          unique case (op_q)
            OP_INSERT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = raddr_q + AW'(1);
            end
            OP_REMOVE: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = raddr_q - AW'(1);
            end
            OP_READ: begin
              rd_d = mem_rdata_i;
            end
            OP_REMOVE_ALL: begin
              if (!match) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = keep_q[AW-1:0];
                keep_d      = keep_q + CW'(1);
              end
            end
            default: begin
            end
          endcase

          if (op_q == OP_FIND && match) begin
            fpos_d   = raddr_q;
            status_d = ST_OK;
            iss_d    = 1'b0;
            rvld_d   = 1'b0;
            state_d  = S_DONE;
          end else if (!iss_q) begin
            // The last element of the walk has just come back.
            unique case (op_q)
              OP_INSERT: begin
                state_d = S_PUT;
              end
              OP_REMOVE: begin
                cnt_d   = cnt_m1;
                state_d = S_DONE;
              end
              OP_FIND: begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end
              OP_REMOVE_ALL: begin
                cnt_d    = keep_d;
                status_d = (keep_d == cnt_q) ? ST_NOT_FOUND : ST_OK;
                state_d  = S_DONE;
              end
              default: begin
                state_d = S_DONE;
              end
            endcase
          end
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CW'(1);
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= '0;
      idx_q    <= '0;
      val_q    <= '0;
      cnt_q    <= '0;
      ptr_q    <= '0;
      stop_q   <= '0;
      iss_q    <= 1'b0;
      rvld_q   <= 1'b0;
      raddr_q  <= '0;
      keep_q   <= '0;
      status_q <= ST_OK;
      rd_q     <= '0;
      fpos_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      stop_q   <= stop_d;
      iss_q    <= iss_d;
      rvld_q   <= rvld_d;
      raddr_q  <= raddr_d;
      keep_q   <= keep_d;
      status_q <= status_d;
      rd_q     <= rd_d;
      fpos_q   <= fpos_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);

  assign len_w  = LW'(cnt_q);
  assign fpos_w = FPW'(fpos_q);

  always_comb begin
    rsp_o                = '0;
    rsp_o.status         = status_q;
    rsp_o.read_value     = rd_q;
    rsp_o.found_position = fpos_w[POS_W-1:0];
    rsp_o.length         = len_w[LEN_W-1:0];
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Capacity))
    else $error("element count exceeds capacity");

  a_write_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CW'(mem_waddr_o) <= cnt_q))
    else $error("store written beyond the end of the list");

  a_full_on_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && status_q == ST_FULL) |-> (op_q == OP_INSERT))
    else $error("full status reported for an operation other than insert");

  a_found_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && op_q == OP_FIND && status_q == ST_OK) |-> (CW'(fpos_q) < cnt_q))
    else $error("found position lies outside the list");

  a_put_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the list by one");

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Insert, remove, read, find, remove-all and length on a packed list.
// ----------------------------------------------------------------------------
// One item is handled at a time. Length requests, rejected requests, appends,
// removals of the last element, and finds and remove-alls on an empty list do
// not walk the element store. Other inserts, removes, reads, finds and
// remove-alls walk it through its single read port, one element per cycle.
// Find stops at the first match. The result sits in an output register, so
// the next item is taken while the previous result still waits. The store
// needs no clearing after reset.
`default_nettype none

module positional_list_engine
  import plm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic             rsp_valid;
  logic             rsp_ready;
  rsp_t             rsp;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  logic out_vld_q;
  rsp_t out_data_q;

  plm_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  plm_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or being
  // emptied in this cycle.
  assign rsp_ready = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rsp_ready) begin
      out_vld_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list engine
// Drives list requests through the valid/ready input, predicts every response
// with an independent list model and checks responses in order, field by
// field, under varying source and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import plm_pkg::*;

  localparam int unsigned LIST_CAP    = CAPACITY_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_SIZE   = 6;

  // Op codes that the package leaves unassigned; the engine must reject them.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_ZERO = 32'h0000_0000;
  localparam logic [VAL_W-1:0] VAL_ONES = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_ONE  = 32'h0000_0001;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  // Model of the list contents and length, updated as each item is accepted.
  logic [VAL_W-1:0] list_store [LIST_CAP];
  int unsigned      list_len;

  rsp_t             pending_rsps [$];
  logic [VAL_W-1:0] value_pool [POOL_SIZE];
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  int unsigned      error_count;
  int unsigned      cycle_count;

  positional_list_engine #(
    .CAPACITY (LIST_CAP)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // Sink side: once reset is released, ready is redrawn at every falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic rsp_t predict_list_op(req_t req);
    rsp_t        rsp;
    int unsigned keep;
    rsp = '0;
    case (req.op)
      OP_INSERT: begin
        if (req.index > list_len) begin
          rsp.status = ST_BAD_POS;
        end else if (list_len >= LIST_CAP) begin
          rsp.status = ST_FULL;
        end else begin
          for (int unsigned i = list_len; i > req.index; i--) begin
            list_store[i] = list_store[i-1];
          end
          list_store[req.index] = req.value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (req.index >= list_len) begin
          rsp.status = ST_BAD_POS;
        end else begin
          for (int unsigned i = req.index; i + 1 < list_len; i++) begin
            list_store[i] = list_store[i+1];
          end
          list_len--;
        end
      end
      OP_READ: begin
        if (req.index >= list_len) begin
          rsp.status = ST_BAD_POS;
        end else begin
          rsp.read_value = list_store[req.index];
        end
      end
      OP_FIND: begin
        rsp.status = ST_NOT_FOUND;
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_store[i] == req.value) begin
            rsp.status         = ST_OK;
            rsp.found_position = i[POS_W-1:0];
            break;
          end
        end
      end
      OP_REMOVE_ALL: begin
        keep = 0;
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_store[i] != req.value) begin
            list_store[keep] = list_store[i];
            keep++;
          end
        end
        rsp.status = (keep == list_len) ? ST_NOT_FOUND : ST_OK;
        list_len   = keep;
      end
      OP_LENGTH: begin
      end
      default: begin
        rsp.status = ST_BAD_POS;
      end
    endcase
    rsp.length = list_len[LEN_W-1:0];
    return rsp;
  endfunction

  // Response checker: every accepted response is matched against the oldest
  // prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: unexpected response %h", $time, out_data_o);
        error_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data_o.status);
          error_count++;
        end
        if (out_data_o.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   want.read_value, out_data_o.read_value);
          error_count++;
        end
        if (out_data_o.found_position !== want.found_position) begin
          $display("%0t: found_position expected %0d actual %0d", $time,
                   want.found_position, out_data_o.found_position);
          error_count++;
        end
        if (out_data_o.length !== want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length,
                   out_data_o.length);
          error_count++;
        end
      end
    end
  end

  function automatic req_t make_req(logic [OP_W-1:0] op, int unsigned idx,
                                    logic [VAL_W-1:0] val);
    req_t req;
    req.op    = op;
    req.index = idx[IDX_W-1:0];
    req.value = val;
    return req;
  endfunction

  // Values mostly come from a small pool so that find and remove-all hit.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 60) begin
      return value_pool[$urandom_range(POOL_SIZE-1)];
    end
    return $urandom();
  endfunction

  // Sends one item. Valid stays high from one item to the next unless the
  // source decides to idle.
  task automatic send_item(input req_t req);
    @(negedge clk_i);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rsps.push_back(predict_list_op(req));
  endtask

  task automatic wait_for_responses();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_edges();
    // Empty list: every positional op and both searches must be rejected.
    send_item(make_req(OP_LENGTH, 0, VAL_ZERO));
    send_item(make_req(OP_REMOVE, 0, VAL_ZERO));
    send_item(make_req(OP_READ, 0, VAL_ZERO));
    send_item(make_req(OP_FIND, 0, VAL_MIN));
    send_item(make_req(OP_REMOVE_ALL, 0, VAL_ZERO));
    send_item(make_req(OP_INSERT, 1, VAL_ONE));
    send_item(make_req(OP_SPARE_6, 63, VAL_ONES));
    send_item(make_req(OP_SPARE_7, 0, VAL_MAX));
    send_item(make_req(OP_INSERT, 0, VAL_MAX));
    send_item(make_req(OP_INSERT, 1, VAL_MIN));
    send_item(make_req(OP_INSERT, 1, VAL_ZERO));
    send_item(make_req(OP_INSERT, 0, VAL_ONES));
    send_item(make_req(OP_INSERT, 5, VAL_ONE));
    send_item(make_req(OP_READ, 3, VAL_ZERO));
    send_item(make_req(OP_READ, 0, VAL_ZERO));
    send_item(make_req(OP_READ, 4, VAL_ZERO));
    send_item(make_req(OP_FIND, 0, VAL_MIN));
    send_item(make_req(OP_FIND, 0, VAL_ONE));
    send_item(make_req(OP_INSERT, 2, VAL_MIN));
    send_item(make_req(OP_REMOVE_ALL, 0, VAL_MIN));
    send_item(make_req(OP_REMOVE, 63, VAL_ZERO));
    send_item(make_req(OP_REMOVE, 2, VAL_ZERO));
    send_item(make_req(OP_REMOVE, 0, VAL_ZERO));
    send_item(make_req(OP_LENGTH, 0, VAL_ZERO));
    send_item(make_req(OP_REMOVE, 0, VAL_ZERO));
  endtask

  task automatic test_fill_to_capacity();
    int unsigned pos;
    while (list_len < LIST_CAP) begin
      pos = (list_len == LIST_CAP - 1) ? list_len : $urandom_range(list_len);
      send_item(make_req(OP_INSERT, pos, pick_value()));
    end
    send_item(make_req(OP_INSERT, 0, VAL_ONE));
    send_item(make_req(OP_INSERT, 63, VAL_ONE));
    send_item(make_req(OP_READ, 63, VAL_ZERO));
    send_item(make_req(OP_FIND, 0, list_store[LIST_CAP-1]));
    send_item(make_req(OP_REMOVE, 63, VAL_ZERO));
    send_item(make_req(OP_INSERT, 63, VAL_ONES));
    send_item(make_req(OP_LENGTH, 63, VAL_ZERO));
    send_item(make_req(OP_REMOVE_ALL, 0, value_pool[$urandom_range(POOL_SIZE-1)]));
  endtask

  // Mostly well-formed requests with in-range positions; about one in seven
  // carries an arbitrary position instead.
  task automatic test_random_mix(input int unsigned count, input int unsigned grow_pct);
    int unsigned      roll;
    int unsigned      pos;
    logic [OP_W-1:0]  op;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = OP_LENGTH;
      end else if (roll < 5) begin
        op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
      end else if (roll < 5 + grow_pct) begin
        op = OP_INSERT;
      end else begin
        roll = $urandom_range(99);
        if (roll < 35) op = OP_REMOVE;
        else if (roll < 65) op = OP_READ;
        else if (roll < 85) op = OP_FIND;
        else op = OP_REMOVE_ALL;
      end
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(63);
      end else if (op == OP_INSERT) begin
        pos = $urandom_range(list_len);
      end else begin
        pos = (list_len == 0) ? 0 : $urandom_range(list_len - 1);
      end
      send_item(make_req(op, pos, pick_value()));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    list_len     = 0;
    error_count  = 0;
    cycle_count  = 0;
    tx_idle_pct  = 9;
    rx_idle_pct  = 57;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = VAL_ZERO;
    value_pool[3] = VAL_ONES;
    value_pool[4] = $urandom();
    value_pool[5] = $urandom();
    for (int unsigned i = 0; i < LIST_CAP; i++) list_store[i] = '0;
    // Count rising edges so that the first clock transition cannot shorten
    // the reset.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_random_mix(250, 50);
    // Let the engine run completely dry before the source side changes pace.
    wait_for_responses();

    tx_idle_pct = 57;
    rx_idle_pct = 9;
    test_fill_to_capacity();
    test_random_mix(250, 40);
    wait_for_responses();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mix(250, 60);
    wait_for_responses();

    // Any stray response would arrive within one full list walk.
    repeat (LIST_CAP + 8) @(posedge clk_i);
    if (error_count == 0 && pending_rsps.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
